[design/asc80_pkg.sv]
package asc80_pkg;

	localparam int RoundsOuterDef = 12;
	localparam int RoundsBlockDef = 6;
	localparam logic [63:0] Iv80pq = 64'ha0400c0600000000;

	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_AD     = 2'd1;
	localparam logic [1:0] ACT_MSG    = 2'd2;
	localparam logic [1:0] ACT_FINISH = 2'd3;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_INIT     = 3'd1;
	localparam logic [2:0] PH_AD_OPEN  = 3'd2;
	localparam logic [2:0] PH_AD_DONE  = 3'd3;
	localparam logic [2:0] PH_MSG_OPEN = 3'd4;
	localparam logic [2:0] PH_MSG_DONE = 3'd5;

	localparam logic [1:0] REG_KEY_TOP    = 2'd0;
	localparam logic [1:0] REG_KEY_MID    = 2'd1;
	localparam logic [1:0] REG_KEY_BOTTOM = 2'd2;

	typedef logic [63:0] lane_t;
	typedef lane_t [4:0] state_t;

	function automatic logic [7:0] round_const(input logic [3:0] i);
		logic [7:0] r;
		begin
			r = {4'hf - i, i};
			return r;
		end
	endfunction

	function automatic state_t ascon_round(input state_t s_in, input logic [3:0] i);
		state_t s;
		lane_t t0, t1, t2, t3, t4;
		begin
			s = s_in;
			s[2] = s[2] ^ {56'd0, round_const(i)};
			s[0] = s[0] ^ s[4]; s[4] = s[4] ^ s[3]; s[2] = s[2] ^ s[1];
			t0 = ~s[0] & s[1]; t1 = ~s[1] & s[2]; t2 = ~s[2] & s[3];
			t3 = ~s[3] & s[4]; t4 = ~s[4] & s[0];
			s[0] = s[0] ^ t1; s[1] = s[1] ^ t2; s[2] = s[2] ^ t3;
			s[3] = s[3] ^ t4; s[4] = s[4] ^ t0;
			s[1] = s[1] ^ s[0]; s[0] = s[0] ^ s[4]; s[3] = s[3] ^ s[2]; s[2] = ~s[2];
			s[0] = s[0] ^ {s[0][18:0], s[0][63:19]} ^ {s[0][27:0], s[0][63:28]};
			s[1] = s[1] ^ {s[1][60:0], s[1][63:61]} ^ {s[1][38:0], s[1][63:39]};
			s[2] = s[2] ^ {s[2][0], s[2][63:1]} ^ {s[2][5:0], s[2][63:6]};
			s[3] = s[3] ^ {s[3][9:0], s[3][63:10]} ^ {s[3][16:0], s[3][63:17]};
			s[4] = s[4] ^ {s[4][6:0], s[4][63:7]} ^ {s[4][40:0], s[4][63:41]};
			return s;
		end
	endfunction

	function automatic lane_t top_mask(input logic [3:0] n);
		lane_t m;
		begin
			m = '0;
			for (int b = 0; b < 8; b++) begin
				if (4'(b) < n) begin
					m[63 - 8*b -: 8] = 8'hff;
				end
			end
			return m;
		end
	endfunction

	function automatic lane_t pad_word(input logic [3:0] n);
		lane_t p;
		begin
			p = '0;
			for (int b = 0; b < 8; b++) begin
				if (4'(b) == n) begin
					p[63 - 8*b] = 1'b1;
				end
			end
			return p;
		end
	endfunction

endpackage

[design/ascon80pq_aead_engine_unit.sv]
// Ascon-80pq AEAD engine.
// Input channel (in_valid/in_ready): one transaction per item; action selects
// start, associated-data chunk, message chunk or finish. Output channel
// (out_valid/out_ready) returns exactly one result transaction per item.
// Key registers are to be written by the user on the cfg port only while
// the engine is idle; the engine does not enforce this. One shared round
// unit runs one permutation round per cycle: start the outer permutation
//   then a key add, a full AD chunk the block permutation (twice when
//   last), a short AD chunk once (none if empty and first), a full message
//   chunk once, a short one and out-of-sequence items none, finish the
//   outer permutation then the tag. The result is held in an output
//   register; the engine takes no new item until that result is taken.
// Reset clears the lanes, phase and key registers; out_valid drops.
// A stalled receiver holds out_valid and the result stable and keeps
// in_ready low.
module ascon80pq_aead_engine_unit
	import asc80_pkg::*;
#(
	parameter int ROUNDS_OUTER = RoundsOuterDef,
	parameter int ROUNDS_BLOCK = RoundsBlockDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        decrypt,
	input  logic [63:0] data_in,
	input  logic [3:0]  data_bytes,
	input  logic        last,
	input  logic [63:0] aux_high,
	input  logic [63:0] aux_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] data_out,
	output logic [3:0]  out_bytes,
	output logic [63:0] tag_high,
	output logic [63:0] tag_low,
	output logic        tag_match,
	output logic        status
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PERM = 2'd1;
	localparam logic [1:0] ST_POST = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam logic [3:0] StartOuter = 4'(12 - ROUNDS_OUTER);
	localparam logic [3:0] StartBlock = 4'(12 - ROUNDS_BLOCK);

	logic [1:0]  state_q;
	state_t      s_q;
	logic [2:0]  phase_q;
	logic        dec_q, sep_q, second_q;
	logic [3:0]  rnd_q;
	logic [1:0]  act_q;
	logic [63:0] exp_hi_q, exp_lo_q;
	logic [31:0] key_top_q;
	logic [63:0] key_mid_q, key_bot_q;
	logic [63:0] dout_q, thi_q, tlo_q;
	logic [3:0]  obytes_q;
	logic        match_q, stat_q;

	logic [3:0]  n;
	lane_t       data, m, sep_w;
	logic        acc, bad;
	state_t      s_rnd;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign acc       = in_valid && in_ready;
	assign n         = (data_bytes > 4'd8) ? 4'd8 : data_bytes;
	assign m         = top_mask(n);
	assign data      = data_in & m;
	assign s_rnd     = ascon_round(s_q, rnd_q);
	assign sep_w     = {63'd0, ~sep_q};

	always_comb begin
		bad = 1'b0;
		case (action)
			ACT_AD: bad = !(phase_q == PH_INIT || phase_q == PH_AD_OPEN) || (!last && n < 4'd8);
			ACT_MSG: bad = !(phase_q == PH_INIT || phase_q == PH_AD_DONE ||
				phase_q == PH_MSG_OPEN) || (!last && n < 4'd8);
			ACT_FINISH: bad = !(phase_q == PH_INIT || phase_q == PH_AD_DONE ||
				phase_q == PH_MSG_DONE);
			default: bad = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_top_q <= '0;
			key_mid_q <= '0;
			key_bot_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_TOP:    key_top_q <= cfg_data[31:0];
				REG_KEY_MID:    key_mid_q <= cfg_data;
				REG_KEY_BOTTOM: key_bot_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			s_q      <= '0;
			phase_q  <= PH_IDLE;
			dec_q    <= 1'b0;
			sep_q    <= 1'b0;
			second_q <= 1'b0;
			rnd_q    <= '0;
			act_q    <= ACT_START;
			exp_hi_q <= '0;
			exp_lo_q <= '0;
			dout_q   <= '0;
			obytes_q <= '0;
			thi_q    <= '0;
			tlo_q    <= '0;
			match_q  <= 1'b0;
			stat_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					act_q    <= action;
					exp_hi_q <= aux_high;
					exp_lo_q <= aux_low;
					dout_q   <= '0;
					obytes_q <= '0;
					thi_q    <= '0;
					tlo_q    <= '0;
					match_q  <= 1'b0;
					stat_q   <= 1'b0;
					second_q <= 1'b0;
					state_q  <= ST_OUT;
					if (action == ACT_START) begin
						s_q[0]  <= Iv80pq ^ {32'd0, key_top_q};
						s_q[1]  <= key_mid_q;
						s_q[2]  <= key_bot_q;
						s_q[3]  <= aux_high;
						s_q[4]  <= aux_low;
						rnd_q   <= StartOuter;
						dec_q   <= decrypt;
						sep_q   <= 1'b0;
						phase_q <= PH_INIT;
						state_q <= ST_PERM;
					end else if (bad) begin
						stat_q <= 1'b1;
					end else if (action == ACT_AD) begin
						phase_q <= last ? PH_AD_DONE : PH_AD_OPEN;
						rnd_q   <= StartBlock;
						if (n == 4'd8) begin
							s_q[0]   <= s_q[0] ^ data;
							second_q <= last;
							state_q  <= ST_PERM;
						end else if (n != 4'd0 || phase_q == PH_AD_OPEN) begin
							s_q[0]  <= s_q[0] ^ data ^ pad_word(n);
							state_q <= ST_PERM;
						end
					end else if (action == ACT_MSG) begin
						phase_q  <= last ? PH_MSG_DONE : PH_MSG_OPEN;
						sep_q    <= 1'b1;
						s_q[4]   <= s_q[4] ^ sep_w;
						obytes_q <= n;
						rnd_q    <= StartBlock;
						if (n == 4'd8) begin
							dout_q   <= s_q[0] ^ data;
							s_q[0]   <= dec_q ? data : (s_q[0] ^ data);
							second_q <= last;
							state_q  <= ST_PERM;
						end else begin
							dout_q <= (s_q[0] ^ pad_word(n) ^ data) & m;
							s_q[0] <= dec_q ? (((s_q[0] ^ pad_word(n)) & ~m) ^ data)
								: (s_q[0] ^ pad_word(n) ^ data);
						end
					end else begin
						phase_q <= PH_IDLE;
						rnd_q   <= StartOuter;
						state_q <= ST_PERM;
						if (phase_q != PH_MSG_DONE) begin
							sep_q  <= 1'b1;
							s_q[4] <= s_q[4] ^ sep_w;
							s_q[0] <= s_q[0] ^ pad_word(4'd0);
						end
						s_q[1] <= s_q[1] ^ {key_top_q, key_mid_q[63:32]};
						s_q[2] <= s_q[2] ^ {key_mid_q[31:0], key_bot_q[63:32]};
						s_q[3] <= s_q[3] ^ {key_bot_q[31:0], 32'd0};
					end
				end
				ST_PERM: begin
					s_q   <= s_rnd;
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'd11) begin
						if (second_q) begin
							second_q <= 1'b0;
							rnd_q    <= StartBlock;
							if (act_q == ACT_MSG) begin
								s_q[0]  <= s_rnd[0] ^ pad_word(4'd0);
								state_q <= ST_OUT;
							end else begin
								s_q[0] <= s_rnd[0] ^ pad_word(4'd0);
							end
						end else begin
							state_q <= (act_q == ACT_START || act_q == ACT_FINISH)
								? ST_POST : ST_OUT;
						end
					end
				end
				ST_POST: begin
					state_q <= ST_OUT;
					if (act_q == ACT_START) begin
						s_q[2] <= s_q[2] ^ {32'd0, key_top_q};
						s_q[3] <= s_q[3] ^ key_mid_q;
						s_q[4] <= s_q[4] ^ key_bot_q;
					end else begin
						s_q[3]  <= s_q[3] ^ key_mid_q;
						s_q[4]  <= s_q[4] ^ key_bot_q;
						thi_q   <= s_q[3] ^ key_mid_q;
						tlo_q   <= s_q[4] ^ key_bot_q;
						match_q <= dec_q && ((s_q[3] ^ key_mid_q) == exp_hi_q) &&
							((s_q[4] ^ key_bot_q) == exp_lo_q);
					end
				end
				ST_OUT: if (out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign data_out  = dout_q;
	assign out_bytes = obytes_q;
	assign tag_high  = thi_q;
	assign tag_low   = tlo_q;
	assign tag_match = match_q;
	assign status    = stat_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !in_ready) else $error("accepted item did not occupy engine");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PERM |-> rnd_q <= 4'd11) else $error("round index out of range");
	a_match_dec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tag_match |-> dec_q) else $error("tag match while encrypting");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import asc80_pkg::*;

	localparam logic ST_SEQ_ERR = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_AD_OPEN, S_AD_DONE, S_MSG_OPEN, S_MSG_DONE
	} sess_t;

	typedef struct {
		logic [1:0]  act;
		logic        dec;
		logic [63:0] data;
		logic [3:0]  nb;
		logic        lst;
		logic [63:0] ah;
		logic [63:0] al;
	} item_t;

	typedef struct {
		logic [63:0] dout;
		logic [3:0]  ob;
		logic [63:0] th;
		logic [63:0] tl;
		logic        tm;
		logic        st;
	} rslt_t;

	typedef struct {
		logic [63:0] s [5];
		sess_t       ph;
		logic        dmode;
		logic        sep;
		logic [31:0] kt;
		logic [63:0] km;
		logic [63:0] kb;
	} eng_t;

	typedef struct {
		item_t it;
		logic  ck_err;
	} row_t;

	logic        clk = 0;
	logic        arst_n;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic        decrypt = 0;
	logic [63:0] data_in = '0;
	logic [3:0]  data_bytes = '0;
	logic        last = 0;
	logic [63:0] aux_high = '0;
	logic [63:0] aux_low = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] data_out;
	logic [3:0]  out_bytes;
	logic [63:0] tag_high;
	logic [63:0] tag_low;
	logic        tag_match;
	logic        status;

	eng_t  model;
	rslt_t exp_q [$];
	int    n_fail = 0;
	int    n_items = 0;
	int    n_seq_err = 0;
	int    n_match = 0;
	int    n_sess = 0;
	int    hold_rx = 0;
	bit    quiet = 0;

	always #1 clk = ~clk;

	ascon80pq_aead_engine_unit dut (.*);

	function automatic logic [63:0] rotr(logic [63:0] v, int r);
		return (v >> r) | (v << (64 - r));
	endfunction

	function automatic logic [63:0] byte_mask(logic [3:0] n);
		return (n == 0) ? 64'h0 : ~64'h0 << (64 - 8 * n);
	endfunction

	function automatic logic [63:0] pad_at(logic [3:0] n);
		return 64'h80 << (56 - 8 * n);
	endfunction

	task automatic permute(inout eng_t e, input int nr);
		logic [63:0] t0, t1, t2, t3, t4;
		for (int i = 12 - nr; i < 12; i++) begin
			e.s[2] ^= 64'(8'hf0 - 8'(15 * i));
			e.s[0] ^= e.s[4]; e.s[4] ^= e.s[3]; e.s[2] ^= e.s[1];
			t0 = ~e.s[0] & e.s[1]; t1 = ~e.s[1] & e.s[2]; t2 = ~e.s[2] & e.s[3];
			t3 = ~e.s[3] & e.s[4]; t4 = ~e.s[4] & e.s[0];
			e.s[0] ^= t1; e.s[1] ^= t2; e.s[2] ^= t3; e.s[3] ^= t4; e.s[4] ^= t0;
			e.s[1] ^= e.s[0]; e.s[0] ^= e.s[4]; e.s[3] ^= e.s[2]; e.s[2] = ~e.s[2];
			e.s[0] ^= rotr(e.s[0], 19) ^ rotr(e.s[0], 28);
			e.s[1] ^= rotr(e.s[1], 61) ^ rotr(e.s[1], 39);
			e.s[2] ^= rotr(e.s[2], 1) ^ rotr(e.s[2], 6);
			e.s[3] ^= rotr(e.s[3], 10) ^ rotr(e.s[3], 17);
			e.s[4] ^= rotr(e.s[4], 7) ^ rotr(e.s[4], 41);
		end
	endtask

	task automatic ascon_step(inout eng_t e, input item_t it, output rslt_t r);
		logic [3:0]  n;
		logic [63:0] d, m;
		r = '{default: '0};
		n = (it.nb > 8) ? 4'd8 : it.nb;
		d = it.data & byte_mask(n);
		case (it.act)
			ACT_START: begin
				e.s[0] = Iv80pq ^ {32'h0, e.kt};
				e.s[1] = e.km; e.s[2] = e.kb; e.s[3] = it.ah; e.s[4] = it.al;
				permute(e, 12);
				e.s[2] ^= {32'h0, e.kt}; e.s[3] ^= e.km; e.s[4] ^= e.kb;
				e.dmode = it.dec; e.sep = 0; e.ph = S_INIT;
			end
			ACT_AD: begin
				if (!(e.ph inside {S_INIT, S_AD_OPEN}) || (!it.lst && n < 8)) begin
					r.st = ST_SEQ_ERR;
				end else begin
					if (n == 8) begin
						e.s[0] ^= d; permute(e, 6);
						if (it.lst) begin
							e.s[0] ^= pad_at(0); permute(e, 6);
						end
					end else if (n > 0 || e.ph == S_AD_OPEN) begin
						e.s[0] ^= d ^ pad_at(n); permute(e, 6);
					end
					e.ph = it.lst ? S_AD_DONE : S_AD_OPEN;
				end
			end
			ACT_MSG: begin
				if (!(e.ph inside {S_INIT, S_AD_DONE, S_MSG_OPEN}) || (!it.lst && n < 8)) begin
					r.st = ST_SEQ_ERR;
				end else begin
					if (!e.sep) begin
						e.s[4] ^= 64'h1; e.sep = 1;
					end
					if (n == 8) begin
						if (e.dmode) begin
							r.dout = e.s[0] ^ d; e.s[0] = d;
						end else begin
							e.s[0] ^= d; r.dout = e.s[0];
						end
						permute(e, 6);
						if (it.lst) e.s[0] ^= pad_at(0);
					end else begin
						m = byte_mask(n);
						e.s[0] ^= pad_at(n);
						if (e.dmode) begin
							r.dout = (e.s[0] ^ d) & m; e.s[0] = (e.s[0] & ~m) ^ d;
						end else begin
							e.s[0] ^= d; r.dout = e.s[0] & m;
						end
					end
					r.ob = n;
					e.ph = it.lst ? S_MSG_DONE : S_MSG_OPEN;
				end
			end
			default: begin
				if (!(e.ph inside {S_INIT, S_AD_DONE, S_MSG_DONE})) begin
					r.st = ST_SEQ_ERR;
				end else begin
					if (e.ph != S_MSG_DONE) begin
						if (!e.sep) begin
							e.s[4] ^= 64'h1; e.sep = 1;
						end
						e.s[0] ^= pad_at(0);
					end
					e.s[1] ^= {e.kt, e.km[63:32]};
					e.s[2] ^= {e.km[31:0], e.kb[63:32]};
					e.s[3] ^= {e.kb[31:0], 32'h0};
					permute(e, 12);
					e.s[3] ^= e.km; e.s[4] ^= e.kb;
					r.th = e.s[3]; r.tl = e.s[4];
					r.tm = e.dmode && e.s[3] == it.ah && e.s[4] == it.al;
					e.ph = S_IDLE;
				end
			end
		endcase
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (quiet || p < 60) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic push_item(item_t it, logic ck_err);
		int    g;
		rslt_t r;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		action <= it.act; decrypt <= it.dec; data_in <= it.data;
		data_bytes <= it.nb; last <= it.lst; aux_high <= it.ah; aux_low <= it.al;
		do @(posedge clk); while (!in_ready);
		ascon_step(model, it, r);
		if (ck_err) r = '{st: ST_SEQ_ERR, default: '0};
		if (r.st == ST_SEQ_ERR) n_seq_err++;
		if (r.tm) n_match++;
		exp_q.push_back(r);
		n_items++;
	endtask

	task automatic drain_and_write(logic [31:0] kt, logic [63:0] km, logic [63:0] kb);
		in_valid <= 0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		cfg_we <= 1; cfg_index <= REG_KEY_TOP; cfg_data <= {32'h0, kt};
		@(posedge clk);
		cfg_index <= REG_KEY_MID; cfg_data <= km;
		@(posedge clk);
		cfg_index <= REG_KEY_BOTTOM; cfg_data <= kb;
		@(posedge clk);
		cfg_we <= 0;
		model.kt = kt; model.km = km; model.kb = kb;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t mk(logic [1:0] a, logic dc, logic [63:0] d, logic [3:0] n,
	                             logic l, logic [63:0] h, logic [63:0] lo);
		item_t it;
		it.act = a; it.dec = dc; it.data = d; it.nb = n; it.lst = l; it.ah = h; it.al = lo;
		return it;
	endfunction

	function automatic item_t rnd_item();
		return mk(2'($urandom), 1'($urandom), rnd64(), 4'($urandom), 1'($urandom),
		          rnd64(), rnd64());
	endfunction

	task automatic send_chunks(logic [1:0] a, int nfull);
		int k;
		for (k = 0; k < nfull; k++)
			push_item(mk(a, 0, rnd64(), ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'd8,
			             0, rnd64(), rnd64()), 0);
		push_item(mk(a, 0, rnd64(), 4'($urandom_range(15)), 1, rnd64(), rnd64()), 0);
	endtask

	task automatic run_session();
		item_t it;
		rslt_t peek;
		eng_t  cp;
		quiet = ($urandom_range(4) == 0);
		n_sess++;
		push_item(mk(ACT_START, 1'($urandom), rnd64(), 4'($urandom), 1'($urandom),
		             rnd64(), rnd64()), 0);
		if ($urandom_range(3) != 0) send_chunks(ACT_AD, $urandom_range(3));
		if ($urandom_range(99) < 8) push_item(rnd_item(), 0);
		if ($urandom_range(4) != 0) send_chunks(ACT_MSG, $urandom_range(4));
		it = mk(ACT_FINISH, 1'($urandom), rnd64(), 4'($urandom), 1'($urandom), rnd64(), rnd64());
		if ($urandom_range(1)) begin
			cp = model;
			ascon_step(cp, it, peek);
			it.ah = peek.th;
			if ($urandom_range(3) != 0) it.al = peek.tl;
		end
		push_item(it, 0);
	endtask

	always @(posedge clk) begin
		rslt_t e;
		if (out_valid && out_ready) begin
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected result transaction", $time);
				n_fail++;
			end else begin
				e = exp_q.pop_front();
				if ({data_out, out_bytes, tag_high, tag_low, tag_match, status} !==
				    {e.dout, e.ob, e.th, e.tl, e.tm, e.st}) begin
					$display("%0t: mismatch exp dout=%h ob=%0d tag=%h_%h tm=%b st=%b",
					         $time, e.dout, e.ob, e.th, e.tl, e.tm, e.st);
					$display("%0t:          act dout=%h ob=%0d tag=%h_%h tm=%b st=%b",
					         $time, data_out, out_bytes, tag_high, tag_low, tag_match, status);
					n_fail++;
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 0;
		end else if (hold_rx > 0) begin
			out_ready <= 0;
			hold_rx--;
		end else if (quiet) begin
			out_ready <= 1;
		end else begin
			out_ready <= ($urandom_range(99) < 70) ||
			             ($urandom_range(99) < 3 ? 0 : (!out_ready && $urandom_range(2) == 0));
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		row_t dir [$];
		arst_n <= 1'b0;
		model.s = '{default: '0};
		model.ph = S_IDLE; model.dmode = 0; model.sep = 0;
		model.kt = '0; model.km = '0; model.kb = '0;

		dir.push_back('{mk(ACT_AD, 0, '1, 8, 1, 0, 0), 1});
		dir.push_back('{mk(ACT_MSG, 1, '1, 8, 1, 0, 0), 1});
		dir.push_back('{mk(ACT_FINISH, 1, 0, 0, 0, '1, '1), 1});
		dir.push_back('{mk(ACT_START, 0, 0, 0, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_AD, 0, '1, 0, 1, 0, 0), 0});
		dir.push_back('{mk(ACT_MSG, 0, '1, 8, 1, 0, 0), 0});
		dir.push_back('{mk(ACT_FINISH, 0, 0, 0, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_START, 1, '1, 15, 1, '1, '1), 0});
		dir.push_back('{mk(ACT_AD, 0, '1, 7, 0, 0, 0), 1});
		dir.push_back('{mk(ACT_AD, 0, 64'h0123456789abcdef, 8, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_AD, 0, '1, 3, 1, 0, 0), 0});
		dir.push_back('{mk(ACT_MSG, 0, 64'hfedcba9876543210, 15, 1, 0, 0), 0});
		dir.push_back('{mk(ACT_AD, 0, '1, 8, 1, 0, 0), 1});
		dir.push_back('{mk(ACT_FINISH, 0, 0, 0, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_FINISH, 0, 0, 0, 0, 0, 0), 1});
		dir.push_back('{mk(ACT_START, 0, 0, 8, 0, 64'h8000000000000000, 64'h1), 0});
		dir.push_back('{mk(ACT_MSG, 0, '1, 8, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_MSG, 0, '1, 0, 1, 0, 0), 0});
		dir.push_back('{mk(ACT_FINISH, 0, 0, 0, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_START, 1, 0, 0, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_FINISH, 0, 0, 0, 0, 0, 0), 0});
		dir.push_back('{mk(ACT_START, 1, 0, 0, 0, '1, 0), 0});
		dir.push_back('{mk(ACT_MSG, 0, 64'h55aa55aa55aa55aa, 5, 1, 0, 0), 0});
		dir.push_back('{mk(ACT_MSG, 0, '1, 5, 1, 0, 0), 1});
		dir.push_back('{mk(ACT_FINISH, 0, 0, 0, 0, 0, 0), 0});

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir[i]) push_item(dir[i].it, dir[i].ck_err);

		drain_and_write('1, '1, '1);
		repeat (3) run_session();
		drain_and_write('0, '0, '0);
		repeat (3) run_session();

		while (n_items < 1240) begin
			if (n_items > 700 && n_items < 720 && hold_rx == 0) hold_rx = 300;
			if ($urandom_range(79) == 0)
				drain_and_write($urandom, rnd64(), rnd64());
			if ($urandom_range(9) == 0) push_item(rnd_item(), 0);
			else run_session();
		end
		in_valid <= 0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d transactions in %0d sessions: %0d out of sequence, %0d tag matches",
		         n_items, n_sess, n_seq_err, n_match);
		if (n_fail == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
